// ----- sv/lli_pkg.sv -----
// line intersection package: status codes, sideband struct, output width
// no dependencies
`default_nettype none
package lli_pkg;

  localparam int OUT_BITS = 48;

  typedef enum logic [1:0] {
    ST_PARALLEL = 2'd0,
    ST_SAME     = 2'd1,
    ST_POINT    = 2'd2
  } status_t;

  // control carried alongside the divider data
  typedef struct packed {
    status_t status;
    logic    neg_x;
    logic    neg_y;
  } lli_side_t;

endpackage
`default_nettype wire

// ----- sv/lli_if.sv -----
// request and result channel interfaces for the line intersection block
// depends on lli_pkg
`default_nettype none
interface lli_in_if #(parameter int CB = 16);
  logic valid;
  logic ready;
  logic signed [CB-1:0] first_start_x;
  logic signed [CB-1:0] first_start_y;
  logic signed [CB-1:0] first_end_x;
  logic signed [CB-1:0] first_end_y;
  logic signed [CB-1:0] second_start_x;
  logic signed [CB-1:0] second_start_y;
  logic signed [CB-1:0] second_end_x;
  logic signed [CB-1:0] second_end_y;
  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y, input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y, output ready);
endinterface

interface lli_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic signed [lli_pkg::OUT_BITS-1:0] cross_x;
  logic signed [lli_pkg::OUT_BITS-1:0] cross_y;
  logic saturated;
  modport source (output valid, status, cross_x, cross_y, saturated, input ready);
  modport sink (input valid, status, cross_x, cross_y, saturated, output ready);
endinterface
`default_nettype wire

// ----- sv/line_line_intersection_top.sv -----
// top level of the line intersection block: front end, division cell chain, rounding
// depends on lli_pkg, lli_if, lli_front, lli_div_cell, lli_round
//
//   channel | dir | payload
//   pair    | in  | two lines, each as start and end point
//   result  | out | status, cross_x, cross_y (Q.FRAC_BITS), saturated
//
// one request per cycle unless a result held at the output stalls the pipeline;
// the chain of division cells computes one quotient bit per cell
// five front stages form d, p, q and the scaled numerators; two back stages round
// and clamp into the output register
// synchronous reset clears only the valid bits of every stage
// a result held at the output stalls the whole pipeline together with pair.ready
`default_nettype none
module line_line_intersection_top #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input wire logic clk,
  input wire logic rst,
  lli_in_if.sink   pair,
  lli_out_if.source result
);
  // widths of the cross products and of the scaled numerator
  localparam int DB = 2 * COORD_BITS + 3;
  localparam int NB = 3 * COORD_BITS + 4 + FRAC_BITS;

  logic en;

  // chain links, index 0 fed by the front end
  logic               cv    [NB+1];
  lli_pkg::lli_side_t cs    [NB+1];
  logic [DB-1:0]      cden  [NB+1];
  logic [DB-1:0]      crx   [NB+1];
  logic [NB-1:0]      cnx   [NB+1];
  logic [DB-1:0]      cry   [NB+1];
  logic [NB-1:0]      cny   [NB+1];

  // whole pipeline moves unless the output holds an untaken result
  assign en         = !result.valid || result.ready;
  assign pair.ready = en;

  lli_front #(.CB(COORD_BITS), .F(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (pair.valid),
    .s1x      (pair.first_start_x),
    .s1y      (pair.first_start_y),
    .e1x      (pair.first_end_x),
    .e1y      (pair.first_end_y),
    .s2x      (pair.second_start_x),
    .s2y      (pair.second_start_y),
    .e2x      (pair.second_end_x),
    .e2y      (pair.second_end_y),
    .out_valid(cv[0]),
    .side     (cs[0]),
    .den      (cden[0]),
    .mag_x    (cnx[0]),
    .mag_y    (cny[0])
  );

  // remainders start at zero
  assign crx[0] = '0;
  assign cry[0] = '0;

  // one cell per quotient bit, most significant first
  for (genvar i = 0; i < NB; i++) begin : g_cell
    lli_div_cell #(.DB(DB), .NB(NB)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_valid (cv[i]),
      .in_side  (cs[i]),
      .in_den   (cden[i]),
      .in_rem_x (crx[i]),
      .in_num_x (cnx[i]),
      .in_rem_y (cry[i]),
      .in_num_y (cny[i]),
      .out_valid(cv[i+1]),
      .out_side (cs[i+1]),
      .out_den  (cden[i+1]),
      .out_rem_x(crx[i+1]),
      .out_num_x(cnx[i+1]),
      .out_rem_y(cry[i+1]),
      .out_num_y(cny[i+1])
    );
  end

  // rounding, clamping and the output register
  lli_round #(.DB(DB), .NB(NB)) u_round (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (cv[NB]),
    .in_side  (cs[NB]),
    .in_den   (cden[NB]),
    .in_rem_x (crx[NB]),
    .in_num_x (cnx[NB]),
    .in_rem_y (cry[NB]),
    .in_num_y (cny[NB]),
    .out_valid(result.valid),
    .status   (result.status),
    .cross_x  (result.cross_x),
    .cross_y  (result.cross_y),
    .saturated(result.saturated)
  );

`ifndef NO_ASSERTIONS
  // no point, no coordinates
  a_no_point_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status != lli_pkg::ST_POINT |->
      result.cross_x == '0 && result.cross_y == '0 && !result.saturated)
    else $error("non-point result carries coordinates");

  // a clamp lands on one of the range limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |->
      result.cross_x == {1'b0, {(lli_pkg::OUT_BITS-1){1'b1}}} ||
      result.cross_x == {1'b1, {(lli_pkg::OUT_BITS-1){1'b0}}} ||
      result.cross_y == {1'b0, {(lli_pkg::OUT_BITS-1){1'b1}}} ||
      result.cross_y == {1'b1, {(lli_pkg::OUT_BITS-1){1'b0}}})
    else $error("saturated without a clamped coordinate");

  // a stall freezes the last division cell
  a_chain_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(cv[NB]) && $stable(cnx[NB]))
    else $error("division chain moved during a stall");
`endif
endmodule
`default_nettype wire

// ----- sv/lli_front.sv -----
// front end: differences, cross products d, p, q, numerators and magnitudes
// depends on lli_pkg
`default_nettype none
module lli_front #(
  parameter int CB = 16,
  parameter int F  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire logic signed [CB-1:0] s1x,
  input  wire logic signed [CB-1:0] s1y,
  input  wire logic signed [CB-1:0] e1x,
  input  wire logic signed [CB-1:0] e1y,
  input  wire logic signed [CB-1:0] s2x,
  input  wire logic signed [CB-1:0] s2y,
  input  wire logic signed [CB-1:0] e2x,
  input  wire logic signed [CB-1:0] e2y,
  output logic out_valid,
  output lli_pkg::lli_side_t side,
  output logic [2*CB+2:0] den,
  output logic [3*CB+3+F:0] mag_x,
  output logic [3*CB+3+F:0] mag_y
);
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int XW = 2 * CB + 3;
  localparam int MW = CB + XW;
  localparam int NW = 3 * CB + 4;
  localparam int NB = NW + F;

  logic [4:0] v;
  // stage 1
  logic signed [DW-1:0] ux, uy, vx, vy, ax, ay, bx, by;
  logic signed [CB-1:0] c1x [3], c1y [3], c2x [3], c2y [3];
  // stage 2
  logic signed [PW-1:0] md1, md2, mp1, mp2, mq1, mq2, mc1, mc2;
  // stage 3
  logic signed [XW-1:0] d3, p3, q3;
  logic cz3;
  // stage 4
  logic signed [MW-1:0] nxp, nxq, nyp, nyq;
  logic signed [XW-1:0] d4;
  logic cz4;

  logic signed [NB-1:0] nxs, nys;

  function automatic logic signed [DW-1:0] sub(input logic signed [CB-1:0] a,
                                               input logic signed [CB-1:0] b);
    sub = DW'(a) - DW'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= sub(e1x, s1x);
      uy <= sub(e1y, s1y);
      vx <= sub(e2x, s2x);
      vy <= sub(e2y, s2y);
      ax <= sub(e1x, s2x);
      ay <= sub(e1y, s2y);
      bx <= sub(s1x, s2x);
      by <= sub(s1y, s2y);
      c1x[0] <= s1x;
      c1y[0] <= s1y;
      c2x[0] <= e1x;
      c2y[0] <= e1y;
      for (int i = 1; i < 3; i++) begin
        c1x[i] <= c1x[i-1];
        c1y[i] <= c1y[i-1];
        c2x[i] <= c2x[i-1];
        c2y[i] <= c2y[i-1];
      end
      md1 <= ux * vy;
      md2 <= uy * vx;
      mp1 <= ax * vy;
      mp2 <= ay * vx;
      mq1 <= vx * by;
      mq2 <= vy * bx;
      mc1 <= ux * by;
      mc2 <= uy * bx;
      d3  <= XW'(md1) - XW'(md2);
      p3  <= XW'(mp1) - XW'(mp2);
      q3  <= XW'(mq1) - XW'(mq2);
      cz3 <= (mc1 == mc2);
      nxp <= MW'(c1x[2]) * MW'(p3);
      nxq <= MW'(c2x[2]) * MW'(q3);
      nyp <= MW'(c1y[2]) * MW'(p3);
      nyq <= MW'(c2y[2]) * MW'(q3);
      d4  <= d3;
      cz4 <= cz3;
      mag_x <= nxs[NB-1] ? NB'(-nxs) : NB'(nxs);
      mag_y <= nys[NB-1] ? NB'(-nys) : NB'(nys);
      den <= d4[XW-1] ? XW'(-d4) : XW'(d4);
      side.neg_x <= nxs[NB-1] ^ d4[XW-1];
      side.neg_y <= nys[NB-1] ^ d4[XW-1];
      if (d4 != '0) begin
        side.status <= lli_pkg::ST_POINT;
      end else if (cz4) begin
        side.status <= lli_pkg::ST_SAME;
      end else begin
        side.status <= lli_pkg::ST_PARALLEL;
      end
    end
  end

  // numerator scaled by the fraction bits
  always_comb begin
    nxs = (NB'(NW'(nxp) + NW'(nxq))) <<< F;
    nys = (NB'(NW'(nyp) + NW'(nyq))) <<< F;
  end

  assign out_valid = v[4];
endmodule
`default_nettype wire

// ----- sv/lli_div_cell.sv -----
// one restoring division step for both coordinates
// depends on lli_pkg
`default_nettype none
module lli_div_cell #(
  parameter int DB = 35,
  parameter int NB = 68
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire lli_pkg::lli_side_t in_side,
  input  wire logic [DB-1:0] in_den,
  input  wire logic [DB-1:0] in_rem_x,
  input  wire logic [NB-1:0] in_num_x,
  input  wire logic [DB-1:0] in_rem_y,
  input  wire logic [NB-1:0] in_num_y,
  output logic out_valid,
  output lli_pkg::lli_side_t out_side,
  output logic [DB-1:0] out_den,
  output logic [DB-1:0] out_rem_x,
  output logic [NB-1:0] out_num_x,
  output logic [DB-1:0] out_rem_y,
  output logic [NB-1:0] out_num_y
);
  logic [DB:0] tx, ty;
  logic gx, gy;

  always_comb begin
    tx = {in_rem_x, in_num_x[NB-1]};
    ty = {in_rem_y, in_num_y[NB-1]};
    gx = tx >= {1'b0, in_den};
    gy = ty >= {1'b0, in_den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_side  <= in_side;
      out_den   <= in_den;
      out_rem_x <= gx ? DB'(tx - {1'b0, in_den}) : DB'(tx);
      out_rem_y <= gy ? DB'(ty - {1'b0, in_den}) : DB'(ty);
      out_num_x <= {in_num_x[NB-2:0], gx};
      out_num_y <= {in_num_y[NB-2:0], gy};
    end
  end
endmodule
`default_nettype wire

// ----- sv/lli_round.sv -----
// rounding, clamping, sign and output register
// depends on lli_pkg
`default_nettype none
module lli_round #(
  parameter int DB = 35,
  parameter int NB = 68
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire logic in_valid,
  input  wire lli_pkg::lli_side_t in_side,
  input  wire logic [DB-1:0] in_den,
  input  wire logic [DB-1:0] in_rem_x,
  input  wire logic [NB-1:0] in_num_x,
  input  wire logic [DB-1:0] in_rem_y,
  input  wire logic [NB-1:0] in_num_y,
  output logic out_valid,
  output logic [1:0] status,
  output logic signed [lli_pkg::OUT_BITS-1:0] cross_x,
  output logic signed [lli_pkg::OUT_BITS-1:0] cross_y,
  output logic saturated
);
  localparam int OB = lli_pkg::OUT_BITS;
  localparam int CW = (NB + 1 > OB + 1) ? NB + 1 : OB + 1;

  logic r_valid;
  lli_pkg::lli_side_t r_side;
  logic [NB:0] qx, qy;
  logic [CW-1:0] lim_x, lim_y, ex, ey, cx, cy, sx, sy;
  logic ovx, ovy, pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      r_valid   <= in_valid;
      out_valid <= r_valid;
    end
  end

  always_comb begin
    ex    = CW'(qx);
    ey    = CW'(qy);
    lim_x = (CW'(1) << (OB - 1)) - CW'(!r_side.neg_x);
    lim_y = (CW'(1) << (OB - 1)) - CW'(!r_side.neg_y);
    ovx   = ex > lim_x;
    ovy   = ey > lim_y;
    cx    = ovx ? lim_x : ex;
    cy    = ovy ? lim_y : ey;
    sx    = r_side.neg_x ? -cx : cx;
    sy    = r_side.neg_y ? -cy : cy;
    pt    = r_side.status == lli_pkg::ST_POINT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // round half away from zero on the magnitude
      qx <= (NB+1)'(in_num_x) + (NB+1)'({in_rem_x, 1'b0} >= {1'b0, in_den});
      qy <= (NB+1)'(in_num_y) + (NB+1)'({in_rem_y, 1'b0} >= {1'b0, in_den});
      r_side    <= in_side;
      status    <= r_side.status;
      cross_x   <= pt ? sx[OB-1:0] : '0;
      cross_y   <= pt ? sy[OB-1:0] : '0;
      saturated <= pt && (ovx || ovy);
    end
  end
endmodule
`default_nettype wire

// ----- sim/line_line_intersection_top_test.sv -----
// self-checking testbench for line_line_intersection_top: predicts status and Q32.16 point
// depends on lli_pkg, lli_if and line_line_intersection_top
`timescale 1ns / 1ps
`default_nettype none
module line_line_intersection_top_test;

  typedef struct {
    lli_pkg::status_t status;
    logic [47:0]      cross_x;
    logic [47:0]      cross_y;
    logic             saturated;
  } point_t;

  typedef logic signed [15:0] coord_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lli_in_if #(.CB(16)) pair ();
  lli_out_if result ();

  line_line_intersection_top #(.COORD_BITS(16), .FRAC_BITS(16)) u_dut (
    .clk(clk), .rst(rst), .pair(pair), .result(result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // expected intersections, oldest first
  point_t expected_points[$];
  int     mismatch_count = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  longint cycle_count = 0;

  // idle time after the last test, covering the pipeline depth plus margin
  localparam int DRAIN_CYCLES = 120;
  localparam longint CYCLE_LIMIT = 400000;

  // one rounded, clamped coordinate: round((a*p + b*q) * 2^16 / d)
  function automatic logic [47:0] scaled_coord(longint a, longint p, longint b, longint q,
                                               longint d, ref logic sat);
    logic signed [127:0] num;
    logic signed [127:0] den;
    logic        [127:0] mag;
    logic        [127:0] dmag;
    logic        [127:0] quo;
    logic        [127:0] rem;
    logic        [127:0] lim;
    logic                neg;
    num = (128'(a) * 128'(p) + 128'(b) * 128'(q)) <<< 16;
    den = 128'(d);
    neg = (num < 0) != (den < 0) && num != 0;
    mag = num < 0 ? -num : num;
    dmag = den < 0 ? -den : den;
    quo = mag / dmag;
    rem = mag % dmag;
    // ties away from zero
    if (rem >= dmag - rem) quo = quo + 1;
    lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 1;
    if (quo > lim) begin
      quo = lim;
      sat = 1'b1;
    end
    return neg ? 48'(-quo) : 48'(quo);
  endfunction

  function automatic point_t predict_point(coord_t s1x, coord_t s1y, coord_t e1x, coord_t e1y,
                                           coord_t s2x, coord_t s2y, coord_t e2x, coord_t e2y);
    point_t r;
    longint ux, uy, vx, vy, d, p, q, c;
    logic   sat;
    ux = longint'(e1x) - s1x;
    uy = longint'(e1y) - s1y;
    vx = longint'(e2x) - s2x;
    vy = longint'(e2y) - s2y;
    d = ux * vy - uy * vx;
    r.cross_x = '0;
    r.cross_y = '0;
    r.saturated = 1'b0;
    if (d == 0) begin
      c = ux * (longint'(s2y) - s1y) - uy * (longint'(s2x) - s1x);
      r.status = (c == 0) ? lli_pkg::ST_SAME : lli_pkg::ST_PARALLEL;
      return r;
    end
    p = (longint'(e1x) - s2x) * vy - (longint'(e1y) - s2y) * vx;
    q = vx * (longint'(s1y) - s2y) - vy * (longint'(s1x) - s2x);
    sat = 1'b0;
    r.status = lli_pkg::ST_POINT;
    r.cross_x = scaled_coord(s1x, p, e1x, q, d, sat);
    r.cross_y = scaled_coord(s1y, p, e1y, q, d, sat);
    r.saturated = sat;
    return r;
  endfunction

  // receiver: random stalls per the current phase
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result checker, compares against the oldest expected point
  always @(posedge clk) begin
    point_t exp_pt;
    cycle_count <= cycle_count + 1;
    if (!rst && result.valid && result.ready) begin
      if (expected_points.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d x %h y %h sat %b",
                   result.status, result.cross_x, result.cross_y, result.saturated);
      end else begin
        exp_pt = expected_points.pop_front();
        if (result.status !== exp_pt.status || result.cross_x !== exp_pt.cross_x ||
            result.cross_y !== exp_pt.cross_y || result.saturated !== exp_pt.saturated) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp status %0d x %h y %h sat %b, got status %0d x %h y %h sat %b",
                     exp_pt.status, exp_pt.cross_x, exp_pt.cross_y, exp_pt.saturated,
                     result.status, result.cross_x, result.cross_y, result.saturated);
        end
      end
    end
  end

  // runaway guard
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_line_intersection_top_test: FAIL");
      $finish;
    end
  end

  // send one request, holding valid until accepted; prediction on acceptance
  task automatic send_pair(coord_t s1x, coord_t s1y, coord_t e1x, coord_t e1y,
                           coord_t s2x, coord_t s2y, coord_t e2x, coord_t e2y);
    while ($urandom_range(99) < send_idle_pct) begin
      pair.valid <= 1'b0;
      @(posedge clk);
    end
    pair.valid <= 1'b1;
    pair.first_start_x <= s1x;
    pair.first_start_y <= s1y;
    pair.first_end_x <= e1x;
    pair.first_end_y <= e1y;
    pair.second_start_x <= s2x;
    pair.second_start_y <= s2y;
    pair.second_end_x <= e2x;
    pair.second_end_y <= e2y;
    @(posedge clk);
    while (!pair.ready) @(posedge clk);
    expected_points.push_back(predict_point(s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y));
  endtask

  // valid drops only when no further request follows directly
  task automatic end_burst();
    pair.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  function automatic coord_t rand_coord(int span);
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(2 * span) - span);
      2: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'($urandom_range(16) - 8);
    endcase
  endfunction

  task automatic test_directed();
    send_pair(0, 0, 1, 1, 0, 1, 1, 0);                       // plain crossing at one half
    send_pair(0, 0, 2, 0, 1, -1, 1, 1);                      // axis crossing
    send_pair(0, 0, 1, 0, 0, 1, 1, 1);                       // parallel distinct
    send_pair(0, 0, 1, 1, 2, 2, 5, 5);                       // same line
    send_pair(3, 3, 3, 3, 7, 7, 7, 7);                       // both degenerate, distinct points
    send_pair(3, 3, 3, 3, 3, 3, 9, 2);                       // degenerate on the other line
    send_pair(-4, 2, -4, 2, 1, 1, 2, 2);                     // degenerate off the other line
    send_pair(0, 0, 3, 0, 0, 1, 1, 4);                       // one third, rounding
    send_pair(0, 0, 3, 0, 0, -1, 1, -4);                     // negative rounding
    send_pair(0, 0, 1, 0, 0, 0, 0, 1);                       // origin
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(-32768, 0, 32767, 1, -32768, 1, 32767, 0);     // near parallel, crossing at x -0.5, y 0.5
    send_pair(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32767);
    send_pair(-32768, -32768, 32767, -32767, 32767, 32767, -32768, 32766);
    send_pair(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh5555, 16'shaaaa,
              16'shaaaa, 16'sh5555);
    send_pair(0, 0, 0, 2, 1, 1, 3, 1);                       // integer crossing at (0, 1)
    send_pair(0, 0, 2, 1, 0, 1, 2, 0);                       // half-unit point
    end_burst();
    wait_drained();
  endtask

  task automatic test_random(int count, int idle_pct, int stall_pct);
    int     span;
    coord_t s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y;
    int     k;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      span = $urandom_range(1) ? 32767 : 100;
      s1x = rand_coord(span); s1y = rand_coord(span);
      e1x = rand_coord(span); e1y = rand_coord(span);
      s2x = rand_coord(span); s2y = rand_coord(span);
      e2x = rand_coord(span); e2y = rand_coord(span);
      case ($urandom_range(7))
        0: begin  // parallel or collinear: second direction a multiple of the first
          k = $urandom_range(1) ? 1 : -1;
          e2x = coord_t'(s2x + k * (e1x - s1x));
          e2y = coord_t'(s2y + k * (e1y - s1y));
          if ($urandom_range(1)) begin
            s2x = s1x; s2y = s1y;
            e2x = coord_t'(s1x + k * (e1x - s1x));
            e2y = coord_t'(s1y + k * (e1y - s1y));
          end
        end
        1: begin  // degenerate first line
          e1x = s1x; e1y = s1y;
        end
        2: begin  // nearly parallel, large result
          e2x = s2x + (e1x - s1x) + coord_t'($urandom_range(2) - 1);
          e2y = s2y + (e1y - s1y);
        end
        default: ;
      endcase
      send_pair(s1x, s1y, e1x, e1y, s2x, s2y, e2x, e2y);
      // the sender pauses until every result is back, once per phase
      if (i == count / 2) begin
        end_burst();
        wait_drained();
      end
    end
    end_burst();
    wait_drained();
  endtask

  initial begin
    pair.valid <= 1'b0;
    pair.first_start_x <= '0;
    pair.first_start_y <= '0;
    pair.first_end_x <= '0;
    pair.first_end_y <= '0;
    pair.second_start_x <= '0;
    pair.second_start_y <= '0;
    pair.second_end_x <= '0;
    pair.second_end_y <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_directed();
    test_random(150, 0, 0);
    test_random(150, 85, 0);
    test_random(150, 0, 85);
    test_random(150, 22, 22);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_points.size() == 0) begin
      $display("line_line_intersection_top_test: PASS");
    end else begin
      $display("line_line_intersection_top_test: FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire
